/* rtl/gsd_pkg.sv */
`default_nettype none
package gsd_pkg;
  localparam int unsigned WrapBitsDefault = 16;
  localparam int unsigned ExpOffset = 2082;

  typedef enum logic [2:0] {
    OP_COUNTER  = 3'd0,
    OP_UNS24    = 3'd1,
    OP_FLOAT48  = 3'd2,
    OP_FIXED48  = 3'd3,
    OP_FLOAT32  = 3'd4,
    OP_SIGNED32 = 3'd5
  } opcode_e;

  // Queue entry: partially decoded item.
  typedef struct packed {
    logic [63:0] value;      // final value for non-counter kinds
    logic        is_float;
    logic        is_counter;
    logic [23:0] raw24;
  } entry_t;

  function automatic logic [7:0] byte_of(input logic [63:0] w, input int unsigned n);
    byte_of = w[63 - 8*n -: 8];
  endfunction

  // Position of the top set bit of a 36-bit value.
  function automatic logic [5:0] top_bit36(input logic [35:0] x);
    logic [5:0] p;
    p = 6'd0;
    for (int i = 0; i < 36; i++) begin
      if (x[i]) p = 6'(i);
    end
    top_bit36 = p;
  endfunction

  function automatic logic [4:0] top_bit23(input logic [22:0] x);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (x[i]) p = 5'(i);
    end
    top_bit23 = p;
  endfunction
endpackage
`default_nettype wire

/* rtl/gsd_front.sv */
`default_nettype none
// Decode every stateless format; counters pass their raw value on.
module gsd_front (
  input  wire logic [63:0]   raw_word_i,
  input  wire logic [2:0]    opcode_i,
  output gsd_pkg::entry_t    entry_o
);
  logic [7:0]  b0, b1, b3, b4, b5, b7;
  logic [35:0] m, mabs;
  logic [5:0]  p;
  logic signed [13:0] be;
  logic [63:0] f48, f32;
  logic [31:0] sbits;
  logic [7:0]  ex;
  logic [22:0] fr;
  logic [4:0]  p32;
  logic [51:0] fr48, fr32;

  always_comb begin
    b0 = gsd_pkg::byte_of(raw_word_i, 0);
    b1 = gsd_pkg::byte_of(raw_word_i, 1);
    b3 = gsd_pkg::byte_of(raw_word_i, 3);
    b4 = gsd_pkg::byte_of(raw_word_i, 4);
    b5 = gsd_pkg::byte_of(raw_word_i, 5);
    b7 = gsd_pkg::byte_of(raw_word_i, 7);

    m    = {b7, b4, b5, b3, b0[7:4]};
    mabs = m[35] ? (~m + 36'd1) : m;
    p    = gsd_pkg::top_bit36(mabs);
    be   = 14'(p) + 14'({b0[3:0], b1}) - 14'(gsd_pkg::ExpOffset) + 14'sd1023;
    fr48 = 52'({16'd0, mabs} << (6'd52 - p));
    if (m == 36'd0 || be < 14'sd1) begin
      f48 = 64'd0;
    end else if (be > 14'sd2046) begin
      f48 = {m[35], 11'h7ff, 52'd0};
    end else begin
      f48 = {m[35], be[10:0], fr48};
    end

    sbits = {b4, b5, b0, b1};
    ex    = sbits[30:23];
    fr    = sbits[22:0];
    p32   = gsd_pkg::top_bit23(fr);
    fr32  = 52'({29'd0, fr} << (6'd52 - 6'(p32)));
    if (ex == 8'hff) begin
      // NaN keeps the payload and gets the quiet bit forced; infinity stays infinity
      f32 = (fr != 23'd0) ? {sbits[31], 11'h7ff, 1'b1, fr[21:0], 29'd0}
                          : {sbits[31], 11'h7ff, 52'd0};
    end else if (ex == 8'd0) begin
      f32 = (fr == 23'd0) ? {sbits[31], 63'd0}
                          : {sbits[31], 11'(11'(p32) + 11'd874), fr32};
    end else begin
      f32 = {sbits[31], 11'(11'(ex) + 11'd896), fr, 29'd0};
    end

    entry_o            = '0;
    entry_o.raw24      = {b3, b0, b1};
    case (opcode_i)
      gsd_pkg::OP_COUNTER:  entry_o.is_counter = 1'b1;
      gsd_pkg::OP_UNS24:    entry_o.value = {40'd0, b3, b0, b1};
      gsd_pkg::OP_FLOAT48: begin
        entry_o.value = f48;
        entry_o.is_float = 1'b1;
      end
      gsd_pkg::OP_FIXED48:  entry_o.value = {{16{b7[7]}}, b7, b4, b5, b3, b0, b1};
      gsd_pkg::OP_FLOAT32: begin
        entry_o.value = f32;
        entry_o.is_float = 1'b1;
      end
      gsd_pkg::OP_SIGNED32: entry_o.value = {{32{b4[7]}}, b4, b5, b0, b1};
      default:              entry_o.value = 64'd0;
    endcase
  end
endmodule
`default_nettype wire

/* rtl/gsd_queue.sv */
`default_nettype none
// Two-entry queue between front and back.
module gsd_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire gsd_pkg::entry_t data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output gsd_pkg::entry_t      data_o,
  output logic                 valid_o
);
  gsd_pkg::entry_t mem_q [2];
  logic rd_q, wr_q;
  logic [1:0] cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= 1'b0;
      wr_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign full_o  = cnt_q[1];
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];
endmodule
`default_nettype wire

/* rtl/gsd_back.sv */
`default_nettype none
// Extend counters, check the period, and hold the result register.
module gsd_back #(
  parameter int unsigned WrapBits = gsd_pkg::WrapBitsDefault
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [23:0]     period_i,
  input  wire logic            valid_i,
  input  wire gsd_pkg::entry_t entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [63:0]          value_o,
  output logic                 is_float_o,
  output logic                 gap_o,
  output logic                 halted_o
);
  localparam int unsigned ExtBits = 24 + WrapBits;

  logic [WrapBits-1:0] wrap_q, wrap_d;
  logic [23:0]         last_raw_q;
  logic [ExtBits-1:0]  last_ext_q, ext;
  logic                seen_q, gap, valid_q;
  logic [63:0]         value_q;
  logic                float_q, gap_q;

  assign pop_o = valid_i && (!valid_q || out_ready_i);

  always_comb begin
    wrap_d = wrap_q + WrapBits'(entry_i.raw24 < last_raw_q);
    ext    = {wrap_d, entry_i.raw24};
    gap    = (last_ext_q != '0) && (ExtBits'(last_ext_q + ExtBits'(period_i)) != ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q     <= '0;
      last_raw_q <= '0;
      last_ext_q <= '0;
      seen_q     <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      if (out_ready_i) valid_q <= 1'b0;
      if (pop_o) begin
        valid_q <= 1'b1;
        if (entry_i.is_counter) begin
          wrap_q     <= wrap_d;
          last_raw_q <= entry_i.raw24;
          last_ext_q <= ext;
          if (gap) seen_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      value_q <= entry_i.is_counter ? 64'(ext) : entry_i.value;
      float_q <= entry_i.is_float;
      gap_q   <= entry_i.is_counter && gap;
    end
  end

  assign out_valid_o = valid_q;
  assign value_o     = value_q;
  assign is_float_o  = float_q;
  assign gap_o       = gap_q;
  assign halted_o    = seen_q;
endmodule
`default_nettype wire

/* rtl/gathered_sample_decoder_top.sv */
`default_nettype none
// Gathered sample decoder.
// Slave stream: s_axis_tdata_i = raw_word (64 bits), s_axis_tuser_i = opcode.
// Master stream: m_axis_tdata_o = value (64 bits), m_axis_tuser_o =
//   {halted, gap_error, value_is_float} from bit 2 down.
// Configuration: cfg_we_i writes sample_period from cfg_wdata_i.
// Each transfer is decoded combinationally in the front part and pushed into a
// two-entry queue; the back part extends counters, checks the period and
// loads the output register. The result is held in the queue and then in the
// output register before it is offered to the sink; throughput is one item
// per cycle while the sink takes one per cycle.
// When the sink stalls the output register holds, the queue fills, and
// s_axis_tready_o drops once both entries are taken.
// Reset clears the counter history, the sticky halt flag, the queue and the
// output valid; sample_period returns to 1.
module gathered_sample_decoder_top #(
  parameter int unsigned WrapBits = gsd_pkg::WrapBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // raw_word
  input  wire logic [2:0]  s_axis_tuser_i,   // opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [63:0]      m_axis_tdata_o,   // value
  output logic [2:0]       m_axis_tuser_o,   // value_is_float, gap_error, halted
  input  wire logic        cfg_we_i,
  input  wire logic [23:0] cfg_wdata_i
);
  logic [23:0] period_q;
  gsd_pkg::entry_t fe, qe;
  logic full, qvalid, pop, push;
  logic is_float, gap, halted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 24'd1;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  assign s_axis_tready_o = !full;
  assign push = s_axis_tvalid_i && !full;

  gsd_front u_front (.raw_word_i(s_axis_tdata_i), .opcode_i(s_axis_tuser_i), .entry_o(fe));

  gsd_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fe), .full_o(full),
    .pop_i(pop), .data_o(qe), .valid_o(qvalid)
  );

  gsd_back #(.WrapBits(WrapBits)) u_back (
    .clk_i, .rst_ni, .period_i(period_q), .valid_i(qvalid), .entry_i(qe),
    .pop_o(pop), .out_valid_o(m_axis_tvalid_o), .out_ready_i(m_axis_tready_i),
    .value_o(m_axis_tdata_o), .is_float_o(is_float), .gap_o(gap), .halted_o(halted)
  );

  assign m_axis_tuser_o = {halted, gap, is_float};

  // Once halted, stays halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni) halted |=> halted)
    else $error("halt flag cleared");
  // A gap on an output implies halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && gap |-> halted)
    else $error("gap without halt");
  // A gap is never flagged on a float result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(gap && is_float))
    else $error("gap on float result");
endmodule
`default_nettype wire
